// ===== hw/rtl/ccor_pkg.sv =====
// Shared types, constants and helpers of the clipped circle outline rasteriser.
package ccor_pkg;

  // Configuration register map
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] RegClipLeft   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegClipTop    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegClipRight  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegClipBottom = 3'd3;
  localparam logic [CfgIdxW-1:0] RegPenColour  = 3'd4;

  localparam int ClipW   = 16;
  localparam int ColourW = 16;
  localparam int MaskW   = 8;

  localparam int ScreenSize = 240;
  localparam logic signed [ClipW-1:0]  ClipLeftRst   = '0;
  localparam logic signed [ClipW-1:0]  ClipTopRst    = '0;
  localparam logic signed [ClipW-1:0]  ClipRightRst  = ClipW'(ScreenSize - 1);
  localparam logic signed [ClipW-1:0]  ClipBottomRst = ClipW'(ScreenSize - 1);
  localparam logic        [ColourW-1:0] PenColourRst = '1;

  // Decision term constants of the circle walk
  localparam int DecInit = 3;
  localparam int DecLo   = 6;
  localparam int DecHi   = 10;

  // Results per command are capped
  localparam int MaxResults = 46;
  localparam int CntW       = $clog2(MaxResults + 1);

  typedef enum logic {
    StIdle,
    StWalk
  } ccor_state_e;

  typedef struct packed {
    logic load;   // latch a new command
    logic step;   // emit one result and advance the walk
  } ccor_cmd_t;

  typedef struct packed {
    logic out_free;  // output register can take a result this cycle
    logic last;      // current iteration is the final one
  } ccor_status_t;

  function automatic logic in_span(logic signed [ClipW-1:0] v,
                                   logic signed [ClipW-1:0] lo,
                                   logic signed [ClipW-1:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

endpackage

// ===== hw/rtl/clipped_circle_outline_raster_top.sv =====
// Clipped circle outline rasteriser: top level with configuration registers.
//
// Input channel (in_valid_i/in_ready_o) carries one circle command: centre
// and radius. Each command produces one result transaction per step of the
// integer circle walk on the output channel (out_valid_o/out_ready_i): the
// eight symmetric points, a clip/duplicate mask, the pen colour and a flag on
// the final step. A radius r gives about r/sqrt(2)+1 results, 45 for r = 63.
// The walk registers advance once per cycle while the output register has
// room, so results stream out at one per cycle. The accepted command loads the
// walk registers, each result then passes into the output register, and the
// next command is accepted once the final result is in the output register.
// The output register holds a result while the receiver stalls; the walk
// waits with it, and a new command may be accepted while the final result of
// the previous one still waits.
// The configuration channel (cfg_valid_i/cfg_ready_o) is always ready; write
// it only while no command is in progress. Reset sets the clip window to
// 0..239 on both axes, the pen colour to white and leaves the block idle.
module clipped_circle_outline_raster_top import ccor_pkg::*; #(
  parameter int RADIUS_BITS = 6,
  parameter int COORD_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic        [CfgIdxW-1:0]     cfg_index_i,
  input  logic        [ClipW-1:0]       cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_BITS-2:0]  center_x_i,
  input  logic signed [COORD_BITS-2:0]  center_y_i,
  input  logic        [RADIUS_BITS-1:0] radius_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [COORD_BITS-1:0]  x_minus_b_o,
  output logic signed [COORD_BITS-1:0]  x_plus_b_o,
  output logic signed [COORD_BITS-1:0]  x_minus_a_o,
  output logic signed [COORD_BITS-1:0]  x_plus_a_o,
  output logic signed [COORD_BITS-1:0]  y_minus_a_o,
  output logic signed [COORD_BITS-1:0]  y_plus_a_o,
  output logic signed [COORD_BITS-1:0]  y_minus_b_o,
  output logic signed [COORD_BITS-1:0]  y_plus_b_o,
  output logic        [MaskW-1:0]       visible_mask_o,
  output logic        [ColourW-1:0]     pixel_colour_o,
  output logic                          last_step_o
);

  logic signed [ClipW-1:0]   clip_left_q, clip_top_q, clip_right_q, clip_bottom_q;
  logic        [ColourW-1:0] pen_colour_q;
  ccor_cmd_t                 cmd;
  ccor_status_t              status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_left_q   <= ClipLeftRst;
      clip_top_q    <= ClipTopRst;
      clip_right_q  <= ClipRightRst;
      clip_bottom_q <= ClipBottomRst;
      pen_colour_q  <= PenColourRst;
    end else if (cfg_valid_i) begin
      // unknown indexes drop the write
      case (cfg_index_i)
        RegClipLeft:   clip_left_q   <= cfg_data_i;
        RegClipTop:    clip_top_q    <= cfg_data_i;
        RegClipRight:  clip_right_q  <= cfg_data_i;
        RegClipBottom: clip_bottom_q <= cfg_data_i;
        RegPenColour:  pen_colour_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ccor_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ccor_dp #(
    .RADIUS_BITS (RADIUS_BITS),
    .COORD_BITS  (COORD_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .center_x_i     (center_x_i),
    .center_y_i     (center_y_i),
    .radius_i       (radius_i),
    .clip_left_i    (clip_left_q),
    .clip_top_i     (clip_top_q),
    .clip_right_i   (clip_right_q),
    .clip_bottom_i  (clip_bottom_q),
    .pen_colour_i   (pen_colour_q),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .x_minus_b_o    (x_minus_b_o),
    .x_plus_b_o     (x_plus_b_o),
    .x_minus_a_o    (x_minus_a_o),
    .x_plus_a_o     (x_plus_a_o),
    .y_minus_a_o    (y_minus_a_o),
    .y_plus_a_o     (y_plus_a_o),
    .y_minus_b_o    (y_minus_b_o),
    .y_plus_b_o     (y_plus_b_o),
    .visible_mask_o (visible_mask_o),
    .pixel_colour_o (pixel_colour_o),
    .last_step_o    (last_step_o)
  );

endmodule

// ===== hw/rtl/ccor_ctrl.sv =====
// Controller state machine: sequences command load and walk steps.
module ccor_ctrl import ccor_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  ccor_status_t status_i,
  output ccor_cmd_t    cmd_o
);

  ccor_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StWalk;
        end
      end
      StWalk: begin
        if (status_i.out_free && status_i.last) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o.load   = 1'b0;
    cmd_o.step   = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      StWalk: begin
        // advance only when the output register has room
        cmd_o.step = status_i.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/ccor_dp.sv =====
// Datapath: walk registers, symmetric points, clip mask and output register.
module ccor_dp import ccor_pkg::*; #(
  parameter int RADIUS_BITS = 6,
  parameter int COORD_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ccor_cmd_t                    cmd_i,
  output ccor_status_t                 status_o,
  input  logic signed [COORD_BITS-2:0] center_x_i,
  input  logic signed [COORD_BITS-2:0] center_y_i,
  input  logic        [RADIUS_BITS-1:0] radius_i,
  input  logic signed [ClipW-1:0]      clip_left_i,
  input  logic signed [ClipW-1:0]      clip_top_i,
  input  logic signed [ClipW-1:0]      clip_right_i,
  input  logic signed [ClipW-1:0]      clip_bottom_i,
  input  logic        [ColourW-1:0]    pen_colour_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [COORD_BITS-1:0] x_minus_b_o,
  output logic signed [COORD_BITS-1:0] x_plus_b_o,
  output logic signed [COORD_BITS-1:0] x_minus_a_o,
  output logic signed [COORD_BITS-1:0] x_plus_a_o,
  output logic signed [COORD_BITS-1:0] y_minus_a_o,
  output logic signed [COORD_BITS-1:0] y_plus_a_o,
  output logic signed [COORD_BITS-1:0] y_minus_b_o,
  output logic signed [COORD_BITS-1:0] y_plus_b_o,
  output logic        [MaskW-1:0]      visible_mask_o,
  output logic        [ColourW-1:0]    pixel_colour_o,
  output logic                         last_step_o
);

  localparam int AW = RADIUS_BITS + 2;
  localparam int DW = RADIUS_BITS + 6;

  logic signed [AW-1:0]         a_q, a_d, b_q, b_d, a_step, b_step, b_init;
  logic signed [DW-1:0]         d_q, d_d, d_step, a_dw, b_dw;
  logic signed [COORD_BITS-1:0] cx_q, cx_d, cy_q, cy_d, a_ext, b_ext;
  logic        [CntW-1:0]       cnt_q, cnt_d;

  logic signed [COORD_BITS-1:0] xmb, xpb, xma, xpa, yma, ypa, ymb, ypb;
  logic                         in_xmb, in_xpb, in_xma, in_xpa;
  logic                         in_yma, in_ypa, in_ymb, in_ypb;
  logic                         a_zero, b_zero, a_eq_b;
  logic        [MaskW-1:0]      mask;
  logic                         last;

  logic                         out_valid_q, out_valid_d;
  logic signed [COORD_BITS-1:0] xmb_q, xpb_q, xma_q, xpa_q, yma_q, ypa_q, ymb_q, ypb_q;
  logic        [MaskW-1:0]      mask_q;
  logic        [ColourW-1:0]    colour_q;
  logic                         last_q;

  // Symmetric points, wrapped at the coordinate width
  always_comb begin
    a_ext = COORD_BITS'(a_q);
    b_ext = COORD_BITS'(b_q);
    xmb   = cx_q - b_ext;
    xpb   = cx_q + b_ext;
    xma   = cx_q - a_ext;
    xpa   = cx_q + a_ext;
    yma   = cy_q - a_ext;
    ypa   = cy_q + a_ext;
    ymb   = cy_q - b_ext;
    ypb   = cy_q + b_ext;
  end

  always_comb begin
    in_xmb = in_span(ClipW'(xmb), clip_left_i, clip_right_i);
    in_xpb = in_span(ClipW'(xpb), clip_left_i, clip_right_i);
    in_xma = in_span(ClipW'(xma), clip_left_i, clip_right_i);
    in_xpa = in_span(ClipW'(xpa), clip_left_i, clip_right_i);
    in_yma = in_span(ClipW'(yma), clip_top_i, clip_bottom_i);
    in_ypa = in_span(ClipW'(ypa), clip_top_i, clip_bottom_i);
    in_ymb = in_span(ClipW'(ymb), clip_top_i, clip_bottom_i);
    in_ypb = in_span(ClipW'(ypb), clip_top_i, clip_bottom_i);
    a_zero = (a_q == '0);
    b_zero = (b_q == '0);
    a_eq_b = (a_q == b_q);
    // drop points that repeat another one of the same octant set
    mask[0] = in_xmb && in_yma;
    mask[1] = !b_zero && in_xpb && in_yma;
    mask[2] = !a_zero && in_xmb && in_ypa;
    mask[3] = !a_zero && !b_zero && in_xpb && in_ypa;
    mask[4] = !a_eq_b && in_xma && in_ymb;
    mask[5] = !a_eq_b && !a_zero && in_xpa && in_ymb;
    mask[6] = !a_eq_b && in_xma && in_ypb;
    mask[7] = !a_eq_b && !a_zero && in_xpa && in_ypb;
  end

  // Decision term update of the walk
  always_comb begin
    a_dw   = DW'(a_q);
    b_dw   = DW'(b_q);
    a_step = a_q + AW'(1);
    if (d_q < 0) begin
      d_step = d_q + (a_dw <<< 2) + DW'(DecLo);
      b_step = b_q;
    end else begin
      d_step = d_q + ((a_dw - b_dw) <<< 2) + DW'(DecHi);
      b_step = b_q - AW'(1);
    end
    last = (a_step > b_step) || (cnt_q == CntW'(MaxResults - 1));
  end

  assign b_init = AW'({1'b0, radius_i});

  always_comb begin
    a_d  = a_q;
    b_d  = b_q;
    d_d  = d_q;
    cx_d = cx_q;
    cy_d = cy_q;
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      a_d   = '0;
      b_d   = b_init;
      d_d   = DW'(DecInit) - (DW'(b_init) <<< 1);
      cx_d  = COORD_BITS'(center_x_i);
      cy_d  = COORD_BITS'(center_y_i);
      cnt_d = '0;
    end else if (cmd_i.step) begin
      a_d   = a_step;
      b_d   = b_step;
      d_d   = d_step;
      cnt_d = cnt_q + CntW'(1);
    end
  end

  always_comb begin
    if (cmd_i.step) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    d_q   <= d_d;
    cx_q  <= cx_d;
    cy_q  <= cy_d;
    cnt_q <= cnt_d;
    if (cmd_i.step) begin
      xmb_q    <= xmb;
      xpb_q    <= xpb;
      xma_q    <= xma;
      xpa_q    <= xpa;
      yma_q    <= yma;
      ypa_q    <= ypa;
      ymb_q    <= ymb;
      ypb_q    <= ypb;
      mask_q   <= mask;
      colour_q <= pen_colour_i;
      last_q   <= last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign status_o.last     = last;

  assign out_valid_o    = out_valid_q;
  assign x_minus_b_o    = xmb_q;
  assign x_plus_b_o     = xpb_q;
  assign x_minus_a_o    = xma_q;
  assign x_plus_a_o     = xpa_q;
  assign y_minus_a_o    = yma_q;
  assign y_plus_a_o     = ypa_q;
  assign y_minus_b_o    = ymb_q;
  assign y_plus_b_o     = ypb_q;
  assign visible_mask_o = mask_q;
  assign pixel_colour_o = colour_q;
  assign last_step_o    = last_q;

endmodule

// ===== hw/rtl/ccor_checker.sv =====
// Port-level checker for the clipped circle outline rasteriser, with its bind.
module ccor_checker import ccor_pkg::*; #(
  parameter int COORD_BITS  = 16
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic signed [COORD_BITS-1:0]  x_minus_b_o,
  input logic signed [COORD_BITS-1:0]  x_plus_b_o,
  input logic signed [COORD_BITS-1:0]  x_minus_a_o,
  input logic signed [COORD_BITS-1:0]  x_plus_a_o,
  input logic signed [COORD_BITS-1:0]  y_minus_a_o,
  input logic signed [COORD_BITS-1:0]  y_plus_a_o,
  input logic signed [COORD_BITS-1:0]  y_minus_b_o,
  input logic signed [COORD_BITS-1:0]  y_plus_b_o,
  input logic        [MaskW-1:0]       visible_mask_o,
  input logic        [ColourW-1:0]     pixel_colour_o,
  input logic                          last_step_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(visible_mask_o) && $stable(last_step_o)
      && $stable(pixel_colour_o)
      && $stable(x_minus_b_o) && $stable(x_plus_b_o)
      && $stable(x_minus_a_o) && $stable(x_plus_a_o)
      && $stable(y_minus_a_o) && $stable(y_plus_a_o)
      && $stable(y_minus_b_o) && $stable(y_plus_b_o))
    else $error("output transaction changed while stalled");

  // one command at a time: a walk blocks the input channel
  a_busy_after_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready while a walk is in progress");

  // set mask bits 1 and 2 never mark a point that repeats its mirror
  a_no_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (visible_mask_o[1] || visible_mask_o[2]) |->
      (!visible_mask_o[1] || (x_plus_b_o != x_minus_b_o)) &&
      (!visible_mask_o[2] || (y_plus_a_o != y_minus_a_o)))
    else $error("visible mask marks a repeated point");

endmodule

bind clipped_circle_outline_raster_top ccor_checker #(
  .COORD_BITS  (COORD_BITS)
) u_ccor_checker (.*);
